>>> rtl/core/gds_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gds_pkg
// Types, constants, calendar functions and the control store of the Gregorian
// date subtraction unit.
// -----------------------------------------------------------------------------
package gds_pkg;

   localparam int PC_W  = 5;
   localparam int REM_W = 19;
   localparam int Q_W   = 10;

   // Reciprocal of 25 scaled by 2**19, exact for every 14-bit year.
   localparam logic [14:0] RECIP25     = 15'd20972;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [8:0] YEAR_LEN_LEAP = 9'd366;
   localparam logic [8:0] YEAR_LEN_NORM = 9'd365;

   localparam logic [4:0] MONTH_LEN_TAB [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic [1:0] {
      CMD_DAYS   = 2'd0,
      CMD_WEEKS  = 2'd1,
      CMD_MONTHS = 2'd2,
      CMD_YEARS  = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_RECIP,
      OP_MOD25,
      OP_CLAMP_DAY,
      OP_REM_INIT,
      OP_SUB_ORDER,
      OP_SUB_YEAR,
      OP_SET_DEC,
      OP_SUB_MONTH,
      OP_SET_DAY,
      OP_STEP_MONTH,
      OP_SUB_YEARS,
      OP_SET_UNDER,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NOT_START,
      CND_IS_YEARS,
      CND_IS_MONTHS,
      CND_K_ZERO,
      CND_REM_LT_YEAR,
      CND_Y_ZERO,
      CND_MONTH_DONE,
      CND_AMT_GT_TOTAL,
      CND_AMT_ZERO,
      CND_AMT_GT_Y
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   // Entry points of the microprogram.
   localparam logic [PC_W-1:0] L_IDLE       = 5'd0;
   localparam logic [PC_W-1:0] L_ORDER_TEST = 5'd6;
   localparam logic [PC_W-1:0] L_YEAR_TEST  = 5'd8;
   localparam logic [PC_W-1:0] L_MONTH_INIT = 5'd11;
   localparam logic [PC_W-1:0] L_MONTH_TEST = 5'd12;
   localparam logic [PC_W-1:0] L_DAY_OUT    = 5'd14;
   localparam logic [PC_W-1:0] L_MONTHS     = 5'd15;
   localparam logic [PC_W-1:0] L_MSTEP_TEST = 5'd16;
   localparam logic [PC_W-1:0] L_YEARS      = 5'd18;
   localparam logic [PC_W-1:0] L_UNDER      = 5'd20;
   localparam logic [PC_W-1:0] L_FINISH     = 5'd21;

   function automatic logic is_leap(input logic [3:0] year_low, input logic [4:0] mod25);
      // Divisible by 4, and not by 25 unless also by 16.
      return (year_low[1:0] == 2'd0) && ((mod25 != 5'd0) || (year_low == 4'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month > MONTH_DEC) begin
         len = 5'd0;
      end else begin
         len = MONTH_LEN_TAB[month];
      end
      if ((month == MONTH_FEB) && leap) begin
         len = 5'd29;
      end
      return len;
   endfunction

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      case (pc)
         5'd0:  w = '{OP_LOAD,       CND_NOT_START,    L_IDLE};
         5'd1:  w = '{OP_RECIP,      CND_NEVER,        L_IDLE};
         5'd2:  w = '{OP_MOD25,      CND_NEVER,        L_IDLE};
         5'd3:  w = '{OP_CLAMP_DAY,  CND_IS_YEARS,     L_YEARS};
         5'd4:  w = '{OP_NOP,        CND_IS_MONTHS,    L_MONTHS};
         5'd5:  w = '{OP_REM_INIT,   CND_NEVER,        L_IDLE};
         5'd6:  w = '{OP_NOP,        CND_K_ZERO,       L_YEAR_TEST};
         5'd7:  w = '{OP_SUB_ORDER,  CND_ALWAYS,       L_ORDER_TEST};
         5'd8:  w = '{OP_NOP,        CND_REM_LT_YEAR,  L_MONTH_INIT};
         5'd9:  w = '{OP_NOP,        CND_Y_ZERO,       L_UNDER};
         5'd10: w = '{OP_SUB_YEAR,   CND_ALWAYS,       L_YEAR_TEST};
         5'd11: w = '{OP_SET_DEC,    CND_NEVER,        L_IDLE};
         5'd12: w = '{OP_NOP,        CND_MONTH_DONE,   L_DAY_OUT};
         5'd13: w = '{OP_SUB_MONTH,  CND_ALWAYS,       L_MONTH_TEST};
         5'd14: w = '{OP_SET_DAY,    CND_ALWAYS,       L_FINISH};
         5'd15: w = '{OP_NOP,        CND_AMT_GT_TOTAL, L_UNDER};
         5'd16: w = '{OP_NOP,        CND_AMT_ZERO,     L_FINISH};
         5'd17: w = '{OP_STEP_MONTH, CND_ALWAYS,       L_MSTEP_TEST};
         5'd18: w = '{OP_NOP,        CND_AMT_GT_Y,     L_UNDER};
         5'd19: w = '{OP_SUB_YEARS,  CND_ALWAYS,       L_FINISH};
         5'd20: w = '{OP_SET_UNDER,  CND_NEVER,        L_IDLE};
         5'd21: w = '{OP_EMIT,       CND_ALWAYS,       L_IDLE};
         default: w = '{OP_NOP,      CND_ALWAYS,       L_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/gregorian_date_subtract.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gregorian_date_subtract
// Microcoded unit that subtracts days, weeks, months or years from a date.
// -----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low; the
// command, amount and start date are sampled there. Busy stays high until the
// result has been produced. Each item gives exactly one result, shown on the
// rsp_ ports for a single cycle while rsp_strobe is high; the receiver has no
// way to stall, so it must take the result in that cycle.
// The run time of an item is set by the microprogram loops:
//   years  : no loop.
//   months : one loop pass per month passed.
//   days   : one loop pass per month before the start month, per year walked
//            and per month walked, where years walked is about
//            (amount + days to year end) / 365, the amount times seven for weeks.
// Underflowing items end early with the date 1/1/0 and rsp_underflow set.
// Items are handled one at a time. A synchronous reset returns the sequencer
// to its idle word, which drops busy, and clears the strobe register.
// -----------------------------------------------------------------------------
module gregorian_date_subtract
   import gds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_amount,
   input  wire logic [4:0]  req_start_day,
   input  wire logic [3:0]  req_start_month,
   input  wire logic [13:0] req_start_year,
   output logic             rsp_strobe,
   output logic [4:0]       rsp_result_day,
   output logic [3:0]       rsp_result_month,
   output logic [13:0]      rsp_result_year,
   output logic             rsp_underflow
);

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic             strobe_ff, strobe_in;
   command_type      cmd_ff, cmd_in;
   logic [15:0]      amt_ff, amt_in;
   logic [4:0]       day_ff, day_in;
   logic [3:0]       month_ff, month_in;
   logic [13:0]      year_ff, year_in;
   logic [4:0]       mod25_ff, mod25_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [3:0]       k_ff, k_in;
   logic             under_ff, under_in;
   logic [4:0]       out_day_ff, out_day_in;
   logic [3:0]       out_month_ff, out_month_in;
   logic [13:0]      out_year_ff, out_year_in;
   logic             out_under_ff, out_under_in;

   ucode_word_type   uw;
   logic             cond_true;
   logic             accept;
   logic             leap;
   logic [8:0]       year_len;
   logic [4:0]       mlen_cur;
   logic [4:0]       mlen_k;
   logic [4:0]       mlen_prev;
   logic [3:0]       month_prev;
   logic [4:0]       mod25_dec;
   logic [28:0]      recip_prod;
   logic [14:0]      q_times25;
   logic [17:0]      month_total;
   logic [REM_W-1:0] rem_base;
   logic [4:0]       day_fixed;

   assign uw     = ucode_rom(pc_ff);
   assign accept = start && (pc_ff == L_IDLE);
   assign busy   = (pc_ff != L_IDLE);

   assign leap       = is_leap(year_ff[3:0], mod25_ff);
   assign year_len   = leap ? YEAR_LEN_LEAP : YEAR_LEN_NORM;
   assign mlen_cur   = month_len(month_ff, leap);
   assign mlen_k     = month_len(k_ff, leap);
   assign month_prev = (month_ff == MONTH_JAN) ? MONTH_DEC : (month_ff - 4'd1);
   // On the wrap to December the year changes, but December never depends on it.
   assign mlen_prev  = month_len(month_prev, leap);
   assign mod25_dec  = (mod25_ff == 5'd0) ? 5'd24 : (mod25_ff - 5'd1);

   assign recip_prod  = {15'd0, year_ff} * {14'd0, RECIP25};
   assign q_times25   = {q_ff, 4'd0} + {1'b0, q_ff, 3'd0} + {5'd0, q_ff};
   assign month_total = {1'b0, year_ff, 3'd0} + {2'd0, year_ff, 2'd0}
                        + {14'd0, month_ff} - 18'd1;
   assign rem_base    = (cmd_ff == CMD_WEEKS)
                        ? ({amt_ff, 3'd0} - {3'd0, amt_ff})
                        : {3'd0, amt_ff};
   assign day_fixed   = (day_ff == 5'd0) ? 5'd1 : day_ff;

   always_comb begin
      case (uw.cond)
         CND_NEVER:        cond_true = 1'b0;
         CND_ALWAYS:       cond_true = 1'b1;
         CND_NOT_START:    cond_true = !start;
         CND_IS_YEARS:     cond_true = (cmd_ff == CMD_YEARS);
         CND_IS_MONTHS:    cond_true = (cmd_ff == CMD_MONTHS);
         CND_K_ZERO:       cond_true = (k_ff == 4'd0);
         CND_REM_LT_YEAR:  cond_true = (rem_ff < {{(REM_W-9){1'b0}}, year_len});
         CND_Y_ZERO:       cond_true = (year_ff == 14'd0);
         CND_MONTH_DONE:   cond_true = (rem_ff < {{(REM_W-5){1'b0}}, mlen_cur})
                                       || (month_ff == MONTH_JAN);
         CND_AMT_GT_TOTAL: cond_true = ({2'd0, amt_ff} > month_total);
         CND_AMT_ZERO:     cond_true = (amt_ff == 16'd0);
         CND_AMT_GT_Y:     cond_true = (amt_ff > {2'd0, year_ff});
         default:          cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = cond_true ? uw.target : (pc_ff + 5'd1);
   end

   always_comb begin
      cmd_in       = cmd_ff;
      amt_in       = amt_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      mod25_in     = mod25_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      under_in     = under_ff;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_under_in = out_under_ff;
      strobe_in    = 1'b0;

      case (uw.op)
         OP_LOAD: begin
            if (accept) begin
               cmd_in   = command_type'(req_command);
               amt_in   = req_amount;
               day_in   = req_start_day;
               year_in  = req_start_year;
               under_in = 1'b0;
               if (req_start_month == 4'd0) begin
                  month_in = MONTH_JAN;
               end else if (req_start_month > MONTH_DEC) begin
                  month_in = MONTH_DEC;
               end else begin
                  month_in = req_start_month;
               end
            end
         end
         OP_RECIP: begin
            q_in = recip_prod[RECIP_SHIFT +: Q_W];
         end
         OP_MOD25: begin
            mod25_in = year_ff[4:0] - q_times25[4:0];
         end
         OP_CLAMP_DAY: begin
            day_in = (day_fixed > mlen_cur) ? mlen_cur : day_fixed;
         end
         OP_REM_INIT: begin
            // The amount plus the days from the start date to the end of its year, the day
            // itself first and the earlier months in the loop that follows.
            rem_in = rem_base + {{(REM_W-9){1'b0}}, year_len}
                     - {{(REM_W-5){1'b0}}, day_ff};
            k_in   = month_ff - 4'd1;
         end
         OP_SUB_ORDER: begin
            rem_in = rem_ff - {{(REM_W-5){1'b0}}, mlen_k};
            k_in   = k_ff - 4'd1;
         end
         OP_SUB_YEAR: begin
            rem_in   = rem_ff - {{(REM_W-9){1'b0}}, year_len};
            year_in  = year_ff - 14'd1;
            mod25_in = mod25_dec;
         end
         OP_SET_DEC: begin
            month_in = MONTH_DEC;
         end
         OP_SUB_MONTH: begin
            rem_in   = rem_ff - {{(REM_W-5){1'b0}}, mlen_cur};
            month_in = month_ff - 4'd1;
         end
         OP_SET_DAY: begin
            day_in = mlen_cur - rem_ff[4:0];
         end
         OP_STEP_MONTH: begin
            month_in = month_prev;
            amt_in   = amt_ff - 16'd1;
            if (month_ff == MONTH_JAN) begin
               year_in  = year_ff - 14'd1;
               mod25_in = mod25_dec;
            end
            if (day_ff > mlen_prev) begin
               day_in = mlen_prev;
            end
         end
         OP_SUB_YEARS: begin
            year_in = year_ff - amt_ff[13:0];
         end
         OP_SET_UNDER: begin
            day_in   = 5'd1;
            month_in = MONTH_JAN;
            year_in  = 14'd0;
            under_in = 1'b1;
         end
         OP_EMIT: begin
            out_day_in   = day_ff;
            out_month_in = month_ff;
            out_year_in  = year_ff;
            out_under_in = under_ff;
            strobe_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= L_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      amt_ff       <= amt_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      mod25_ff     <= mod25_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      k_ff         <= k_in;
      under_ff     <= under_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_under_ff <= out_under_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_day   = out_day_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_year  = out_year_ff;
   assign rsp_underflow    = out_under_ff;

   // An accepted item keeps the unit busy from the next cycle on.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an item was accepted");

   // A result strobe never comes back to back.
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A saturated result is always the first of January, year 0.
   a_under_date : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_underflow) |->
         (rsp_result_day == 5'd1) && (rsp_result_month == MONTH_JAN)
         && (rsp_result_year == 14'd0))
      else $error("underflow result is not 1/1/0");

   // Every result date has a real month and a day of at least one.
   a_date_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_result_month >= MONTH_JAN) && (rsp_result_month <= MONTH_DEC)
         && (rsp_result_day != 5'd0))
      else $error("result date out of range");

endmodule
`default_nettype wire
